>>> rtl/assert_macros.svh
// assertion macros shared by the sprite framebuffer modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

>>> rtl/sxfb_pkg.sv
// shared types, codes and constant tables for the sprite framebuffer
// used by sxfb_ctrl, sxfb_datapath and sprite_xor_framebuffer
package sxfb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 64;
    localparam int DEF_SCREEN_HEIGHT = 32;

    localparam int ROW_BITS    = 64;
    localparam int SPRITE_BITS = 8;
    localparam int COORD_W     = 6;
    localparam int POS_W       = 7;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_DRAW  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    typedef logic [255:0][COORD_W-1:0] mod_tbl_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } sxfb_cmd_t;

    // residue of every 8-bit value modulo m, built by counting
    function automatic mod_tbl_t mod_table(input int m);
        mod_tbl_t t;
        int       r;
        int       i;
        r = 0;
        for (i = 0; i < 256; i++)
        begin
            t[i] = COORD_W'(r);
            r = r + 1;
            if (r == m)
            begin
                r = 0;
            end
        end
        return t;
    endfunction

endpackage

>>> rtl/sxfb_ctrl.sv
// controller: sequences accept, row read-modify-write and result handoff
// depends on sxfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module sxfb_ctrl
    import sxfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output sxfb_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && s_tvalid;
        cmd.finish = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a new result replaces one that leaves in the same cycle
        if (cmd.finish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    `ASSERT_NEVER(a_no_overlap, cmd.accept && cmd.finish, "accept and finish in one cycle")
    `ASSERT_PROP(a_hold_exec, (state_reg == ST_EXEC) && m_tvalid_reg && !m_tready |=> (state_reg == ST_EXEC), "item left exec while output blocked")
    `ASSERT_PROP(a_finish_valid, cmd.finish |=> m_tvalid_reg, "finished item not offered")

endmodule

>>> rtl/sxfb_datapath.sv
// datapath: row memory with valid bits, sprite mask, collision and draw flag
// depends on sxfb_pkg and assert_macros.svh
`include "assert_macros.svh"

module sxfb_datapath
    import sxfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sxfb_cmd_t              cmd,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   s_tlast,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int       ROW_AW = $clog2(SCREEN_HEIGHT);
    localparam mod_tbl_t X_MOD  = mod_table(SCREEN_WIDTH);
    localparam mod_tbl_t Y_MOD  = mod_table(SCREEN_HEIGHT);
    localparam logic [POS_W-1:0] WIDTH_LIM  = POS_W'(SCREEN_WIDTH);
    localparam logic [POS_W-1:0] HEIGHT_LIM = POS_W'(SCREEN_HEIGHT);

    // input word fields
    logic [7:0] in_x_pos;
    logic [7:0] in_y_pos;
    logic [3:0] in_row_offset;
    logic [7:0] in_sprite_byte;
    logic [4:0] in_read_line;

    logic [POS_W-1:0]  draw_row;
    logic [POS_W-1:0]  read_row;
    logic              draw_ok;
    logic              read_ok;
    logic [ROW_AW-1:0] rd_addr;

    logic [ROW_BITS-1:0] mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] row_valid_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_valid_reg;

    logic [1:0]         func_reg;
    logic [COORD_W-1:0] x0_reg;
    logic [7:0]         sprite_reg;
    logic               last_reg;
    logic               row_ok_reg;
    logic               read_ok_reg;
    logic [ROW_AW-1:0]  addr_reg;

    logic collision_acc_reg;
    logic collision_acc_next;
    logic redraw_reg;
    logic redraw_next;

    logic [OUT_TDATA_W-7:0] out_data_reg;

    logic [ROW_BITS-1:0] cur_row;
    logic [ROW_BITS-1:0] mask;
    logic [POS_W-1:0]    pos;
    logic                hit;
    logic                do_write;
    logic                coll_out;
    logic [ROW_BITS-1:0] line_out;

    assign in_x_pos       = s_tdata[7:0];
    assign in_y_pos       = s_tdata[15:8];
    assign in_row_offset  = s_tdata[19:16];
    assign in_sprite_byte = s_tdata[27:20];
    assign in_read_line   = s_tdata[32:28];

    always_comb
    begin
        draw_row = POS_W'(Y_MOD[in_y_pos]) + POS_W'(in_row_offset);
        read_row = POS_W'(in_read_line);
        draw_ok  = draw_row < HEIGHT_LIM;
        read_ok  = read_row < HEIGHT_LIM;
        if (s_tuser == FUNC_DRAW)
        begin
            rd_addr = draw_row[ROW_AW-1:0];
        end
        else
        begin
            rd_addr = read_row[ROW_AW-1:0];
        end
    end

    // single row port: read on accept, write back on finish
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
            func_reg     <= s_tuser;
            x0_reg       <= X_MOD[in_x_pos];
            sprite_reg   <= in_sprite_byte;
            last_reg     <= s_tlast;
            row_ok_reg   <= draw_ok;
            read_ok_reg  <= read_ok;
            addr_reg     <= rd_addr;
        end
        if (do_write)
        begin
            mem[addr_reg] <= cur_row ^ mask;
        end
        if (cmd.finish)
        begin
            out_data_reg <= {redraw_next, line_out, coll_out};
        end
    end

    always_comb
    begin
        cur_row = rd_valid_reg ? rd_data_reg : '0;

        // clip at the right edge, msb of the sprite is leftmost
        mask = '0;
        pos  = '0;
        for (int c = 0; c < SPRITE_BITS; c++)
        begin
            pos = POS_W'(x0_reg) + POS_W'(c);
            if (sprite_reg[SPRITE_BITS-1-c] && (pos < WIDTH_LIM))
            begin
                mask[~pos[COORD_W-1:0]] = 1'b1;
            end
        end

        do_write = cmd.finish && (func_reg == FUNC_DRAW) && row_ok_reg;
        hit      = do_write && ((cur_row & mask) != '0);

        collision_acc_next = collision_acc_reg;
        redraw_next        = redraw_reg;
        coll_out           = 1'b0;
        line_out           = '0;
        case (func_reg)
            FUNC_CLEAR:
            begin
                collision_acc_next = 1'b0;
                redraw_next        = 1'b1;
            end
            FUNC_DRAW:
            begin
                if (last_reg)
                begin
                    coll_out           = collision_acc_reg | hit;
                    collision_acc_next = 1'b0;
                    redraw_next        = 1'b1;
                end
                else
                begin
                    collision_acc_next = collision_acc_reg | hit;
                end
            end
            FUNC_READ:
            begin
                if (read_ok_reg)
                begin
                    line_out = cur_row;
                end
            end
            default:
            begin
                collision_acc_next = collision_acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg     <= '0;
            collision_acc_reg <= 1'b0;
            redraw_reg        <= 1'b0;
        end
        else if (cmd.finish)
        begin
            collision_acc_reg <= collision_acc_next;
            redraw_reg        <= redraw_next;
            // clear drops every row at once, unwritten rows read as off
            if (func_reg == FUNC_CLEAR)
            begin
                row_valid_reg <= '0;
            end
            else if (do_write)
            begin
                row_valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    assign m_tdata = {6'b0, out_data_reg};

    `ASSERT_PROP(a_clear_rows,
        cmd.finish && (func_reg == FUNC_CLEAR) |=> (row_valid_reg == '0),
        "rows still valid after clear")
    `ASSERT_PROP(a_last_flag,
        cmd.finish && (func_reg == FUNC_DRAW) && last_reg |=> redraw_reg && !collision_acc_reg,
        "last row did not set flag or reset collision")
    `ASSERT_PROP(a_coll_last,
        cmd.finish && !((func_reg == FUNC_DRAW) && last_reg) |=> !out_data_reg[0],
        "collision reported off the last row")

endmodule

>>> rtl/sprite_xor_framebuffer.sv
// m_tvalid rises once the accepted word has left the exec state and its result
//   is registered; a new word is taken only after the last one ends the read-modify-write of one
//   framebuffer row through the single row port of the row memory
// a waiting result lets one more word in, which then holds until it leaves
// reset (async, active low) clears control, draw flag, collision and all
//   row valid bits at once: every pixel reads off with no clearing pass
module sprite_xor_framebuffer
    import sxfb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // x_pos[7:0], y_pos[15:8], row_offset[19:16], sprite_byte[27:20],
    // read_line[32:28], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]             s_tuser,
    // last_row
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // collision[0], line_bits[64:1], draw_pending[65], zero fill above
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    sxfb_cmd_t cmd;

    sxfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sxfb_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tdata (m_tdata)
    );

endmodule

>>> sim/tb_sprite_xor_framebuffer.sv
// self-checking bench for sprite_xor_framebuffer: streams clear, sprite-row and
// row-read words and mirrors the 64x32 pixel store to check every reply word
// depends on sxfb_pkg and the sprite_xor_framebuffer rtl
`timescale 1ns / 1ps

module tb_sprite_xor_framebuffer;
    import sxfb_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int STALL_LIMIT = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int WORD_TARGET = 550;
    localparam int MAX_REPORTS = 100;

    typedef struct {
        logic                collision;
        logic [ROW_BITS-1:0] line_bits;
        logic                draw_pending;
    } reply_t;

    // mirror of the pixel store plus the replies it predicts
    class frame_mirror;
        logic [ROW_BITS-1:0] rows [DEF_SCREEN_HEIGHT];
        logic                coll_acc;
        logic                redraw;
        reply_t              reply_q [$];
        int                  errors;
        int                  words;
        int                  reads;
        int                  sprites;
        int                  hits;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            coll_acc  = 1'b0;
            redraw    = 1'b0;
            errors    = 0;
            words     = 0;
            reads     = 0;
            sprites   = 0;
            hits      = 0;
        endfunction

        function void note_word(input logic [1:0] func, input logic [7:0] x, input logic [7:0] y,
                                input logic [3:0] off, input logic [7:0] spr, input logic last,
                                input logic [4:0] line);
            reply_t              r;
            int                  x0;
            int                  row;
            logic [ROW_BITS-1:0] mask;
            r.collision = 1'b0;
            r.line_bits = '0;
            words++;
            case (func)
                FUNC_CLEAR:
                begin
                    foreach (rows[i])
                        rows[i] = '0;
                    coll_acc  = 1'b0;
                    redraw    = 1'b1;
                end
                FUNC_DRAW:
                begin
                    x0   = int'(x) % DEF_SCREEN_WIDTH;
                    row  = int'(y) % DEF_SCREEN_HEIGHT + int'(off);
                    mask = '0;
                    // pixels past the right edge are dropped
                    for (int c = 0; c < SPRITE_BITS; c++)
                    begin
                        if (spr[SPRITE_BITS-1-c] && x0 + c < DEF_SCREEN_WIDTH)
                            mask[ROW_BITS-1-(x0+c)] = 1'b1;
                    end
                    if (row < DEF_SCREEN_HEIGHT)
                    begin
                        if ((rows[row] & mask) != '0)
                            coll_acc = 1'b1;
                        rows[row] ^= mask;
                    end
                    if (last)
                    begin
                        r.collision = coll_acc;
                        coll_acc    = 1'b0;
                        redraw      = 1'b1;
                        sprites++;
                    end
                end
                FUNC_READ:
                begin
                    reads++;
                    if (line < DEF_SCREEN_HEIGHT)
                        r.line_bits = rows[line];
                end
                default:
                begin
                end
            endcase
            r.draw_pending = redraw;
            reply_q.push_back(r);
        endfunction

        function void report_field(input string name, input logic [ROW_BITS-1:0] want,
                                   input logic [ROW_BITS-1:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_reply(input logic [OUT_TDATA_W-1:0] d);
            reply_t r;
            if (reply_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word expected none actual %h", $time, d);
                return;
            end
            r = reply_q.pop_front();
            if (d[0])
                hits++;
            report_field("collision", ROW_BITS'(r.collision), ROW_BITS'(d[0]));
            report_field("line_bits", r.line_bits, d[ROW_BITS:1]);
            report_field("draw_pending", ROW_BITS'(r.draw_pending), ROW_BITS'(d[ROW_BITS+1]));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    frame_mirror mirror = new();
    bit          steady;
    int          stall_cycles;
    int          sent;

    sprite_xor_framebuffer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // accepted words on both sides, input first
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            mirror.note_word(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[19:16],
                             s_tdata[27:20], s_tlast, s_tdata[32:28]);
        if (rst_n && m_tvalid && m_tready)
            mirror.check_reply(m_tdata);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("sprite_xor_framebuffer: mismatch");
                $finish;
            end
        end
    end

    // reply side backpressure
    initial
    begin
        int gap;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic send_word(input logic [1:0] func, input logic [7:0] x, input logic [7:0] y,
                             input logic [3:0] off, input logic [7:0] spr, input logic last,
                             input logic [4:0] line);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tlast  <= last;
        s_tdata  <= {7'b0, line, spr, off, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    task automatic draw_row(input logic [7:0] x, input logic [7:0] y, input logic [3:0] off,
                            input logic [7:0] spr, input logic last);
        send_word(FUNC_DRAW, x, y, off, spr, last, 5'($urandom));
    endtask

    task automatic read_row(input logic [4:0] line);
        send_word(FUNC_READ, 8'($urandom), 8'($urandom), 4'($urandom), 8'($urandom),
                  1'($urandom), line);
    endtask

    task automatic random_sprite();
        logic [7:0] x;
        logic [7:0] y;
        int         n;
        bit         broken;
        // clustered origins make overlaps and collisions common
        x      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        y      = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        n      = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5);
        broken = ($urandom_range(0, 9) == 0);
        for (int r = 0; r < n; r++)
        begin
            if (broken)
                draw_row(x, y, 4'($urandom), 8'($urandom), 1'($urandom));
            else
                draw_row(x, y, 4'(r), 8'($urandom), r == n - 1);
        end
    endtask

    initial
    begin
        int pick;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_CLEAR;
        s_tlast  = 1'b0;
        steady   = 1'b0;
        sent     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners
        read_row(5'd0);
        send_word(FUNC_SPARE, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'd31);
        draw_row(8'd0, 8'd0, 4'd0, 8'hff, 1'b0);
        draw_row(8'd0, 8'd0, 4'd1, 8'h81, 1'b1);
        draw_row(8'd0, 8'd0, 4'd0, 8'h0f, 1'b1);
        read_row(5'd0);
        read_row(5'd1);
        // right edge clipping
        draw_row(8'd60, 8'd5, 4'd0, 8'hff, 1'b1);
        read_row(5'd5);
        // origin wraps to the last column and row, then a row past the bottom
        draw_row(8'd255, 8'd255, 4'd0, 8'hff, 1'b0);
        draw_row(8'd255, 8'd255, 4'd15, 8'hff, 1'b1);
        read_row(5'd31);
        draw_row(8'd64, 8'd200, 4'd15, 8'hc3, 1'b1);
        read_row(5'd23);
        // clear in the middle of a sprite drops the pending collision
        draw_row(8'd0, 8'd0, 4'd0, 8'hff, 1'b0);
        draw_row(8'd0, 8'd0, 4'd0, 8'hff, 1'b0);
        send_word(FUNC_CLEAR, 8'hff, 8'hff, 4'hf, 8'hff, 1'b1, 5'd31);
        draw_row(8'd0, 8'd0, 4'd0, 8'h00, 1'b1);
        read_row(5'd0);
        read_row(5'd31);
        send_word(FUNC_SPARE, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd0);

        while (sent < WORD_TARGET)
        begin
            steady = ($urandom_range(0, 7) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 70)
                random_sprite();
            else if (pick < 92)
                read_row(5'($urandom));
            else if (pick < 96)
                send_word(FUNC_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 5'($urandom));
            else
                send_word(FUNC_SPARE, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 5'($urandom));
        end
        s_tvalid <= 1'b0;

        while (mirror.reply_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d words: %0d sprites closed, %0d row reads, %0d collisions seen",
                 mirror.words, mirror.sprites, mirror.reads, mirror.hits);
        if (mirror.errors == 0 && mirror.reply_q.size() == 0)
            $display("sprite_xor_framebuffer: match");
        else
            $display("sprite_xor_framebuffer: mismatch");
        $finish;
    end

endmodule

>>> sprite_xor_framebuffer.f
+incdir+rtl
rtl/sxfb_pkg.sv
rtl/sxfb_ctrl.sv
rtl/sxfb_datapath.sv
rtl/sprite_xor_framebuffer.sv
sim/tb_sprite_xor_framebuffer.sv
